[hw/rtl/mcbq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcbq_pkg
// Shared sizes, codes and types of the multichannel biquad filter bank.
// ----------------------------------------------------------------------------
package mcbq_pkg;

    localparam int CHANNELS  = 5;
    localparam int ORDER     = 2;
    localparam int NCOEF     = 2 * ORDER + 1;

    localparam int CH_W      = 3;
    localparam int IDX_W     = 3;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int FRAC_BITS = 14;

    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int COEF_IDX_W = $clog2(NCOEF);
    localparam int ACC_W      = COEF_W + SAMPLE_W + $clog2(NCOEF) + 1;

    typedef enum logic
    {
        ACT_FILTER = 1'b0,
        ACT_WRITE  = 1'b1
    } action_t;

    typedef logic [NCOEF-1:0][COEF_W-1:0]   coef_row_t;
    typedef logic [ORDER-1:0][SAMPLE_W-1:0] hist_row_t;

    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       clipped;
    } mac_result_t;

endpackage : mcbq_pkg
`default_nettype wire

[hw/rtl/mcbq_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcbq channel interfaces
// Valid/ready channels for request items and filter result items.
// ----------------------------------------------------------------------------
interface mcbq_sample_if;
    import mcbq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           coef_index;
    logic signed [COEF_W-1:0]   coef_value;

    modport source (output valid, action, channel, sample, coef_index, coef_value,
                    input ready);
    modport sink   (input valid, action, channel, sample, coef_index, coef_value,
                    output ready);
endinterface : mcbq_sample_if

interface mcbq_result_if;
    import mcbq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CH_W-1:0]            out_channel;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;

    modport source (output valid, out_channel, filtered, clipped, input ready);
    modport sink   (input valid, out_channel, filtered, clipped, output ready);
endinterface : mcbq_result_if
`default_nettype wire

[hw/rtl/multichannel_biquad_iir_filter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_biquad_iir_filter_unit
// Bank of per-channel second-order direct-form-I IIR filters with a
// coefficient table written through the request channel.
//
//   port     | role   | moves
//   ---------+--------+----------------------------------------------------
//   samples  | sink   | sample item or coefficient write item
//   results  | source | channel, rounded/saturated output and clip flag
//
// One item per cycle: an item is held in the input register, the
// multiply-accumulate runs into the result register, and the channel's
// histories update on the same edge, so a following item on the same
// channel sees them. Reset clears histories and coefficients. A waiting
// result stalls intake only when the next item also makes a result.
// ----------------------------------------------------------------------------
module multichannel_biquad_iir_filter_unit
    import mcbq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    mcbq_sample_if.sink   samples,
    mcbq_result_if.source results
);

    logic                       in_valid_reg;
    logic                       action_reg;
    logic [CH_W-1:0]            channel_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [IDX_W-1:0]           coef_index_reg;
    logic signed [COEF_W-1:0]   coef_value_reg;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [CH_W-1:0]            out_channel_reg;
    logic signed [SAMPLE_W-1:0] filtered_reg;
    logic                       clipped_reg;

    coef_row_t                  coef_reg [CHANNELS];
    hist_row_t                  past_in_reg [CHANNELS];
    hist_row_t                  past_out_reg [CHANNELS];

    logic [CH_IDX_W-1:0]        ch_idx;
    logic [COEF_IDX_W-1:0]      cf_idx;
    logic                       ch_ok;
    logic                       produce;
    logic                       do_write;
    logic                       stage_go;
    logic                       accept;
    mac_result_t                mac_out;

    assign ch_idx   = CH_IDX_W'(channel_reg);
    assign cf_idx   = COEF_IDX_W'(coef_index_reg);
    assign ch_ok    = (int'(channel_reg) < CHANNELS);
    assign produce  = in_valid_reg && ch_ok && (action_reg == ACT_FILTER);
    assign do_write = in_valid_reg && ch_ok && (action_reg == ACT_WRITE)
                      && (int'(coef_index_reg) < NCOEF);
    assign stage_go = in_valid_reg && (!produce || !out_valid_reg || results.ready);
    assign accept   = samples.valid && samples.ready;

    assign samples.ready = !in_valid_reg || stage_go;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg     <= samples.action;
            channel_reg    <= samples.channel;
            sample_reg     <= samples.sample;
            coef_index_reg <= samples.coef_index;
            coef_value_reg <= samples.coef_value;
        end
    end

    mcbq_mac u_mac
    (
        .coefs  (coef_reg[ch_idx]),
        .x      (sample_reg),
        .xh     (past_in_reg[ch_idx]),
        .yh     (past_out_reg[ch_idx]),
        .result (mac_out)
    );

    // coefficient table and histories
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                coef_reg[c]     <= '0;
                past_in_reg[c]  <= '0;
                past_out_reg[c] <= '0;
            end
        end
        else if (stage_go)
        begin
            if (do_write)
            begin
                coef_reg[ch_idx][cf_idx] <= coef_value_reg;
            end
            if (produce)
            begin
                for (int k = ORDER - 1; k > 0; k--)
                begin
                    past_in_reg[ch_idx][k]  <= past_in_reg[ch_idx][k - 1];
                    past_out_reg[ch_idx][k] <= past_out_reg[ch_idx][k - 1];
                end
                past_in_reg[ch_idx][0]  <= sample_reg;
                past_out_reg[ch_idx][0] <= mac_out.filtered;
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !results.ready;
        if (stage_go && produce)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && produce)
        begin
            out_channel_reg <= channel_reg;
            filtered_reg    <= mac_out.filtered;
            clipped_reg     <= mac_out.clipped;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.out_channel = out_channel_reg;
    assign results.filtered    = filtered_reg;
    assign results.clipped     = clipped_reg;

endmodule : multichannel_biquad_iir_filter_unit
`default_nettype wire

[hw/rtl/mcbq_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcbq_mac
// Direct-form-I multiply-accumulate, round half up from Q14 and saturate.
// ----------------------------------------------------------------------------
module mcbq_mac
    import mcbq_pkg::*;
(
    input  wire coef_row_t                  coefs,
    input  wire logic signed [SAMPLE_W-1:0] x,
    input  wire hist_row_t                  xh,
    input  wire hist_row_t                  yh,
    output mac_result_t                     result
);

    localparam int PROD_W = COEF_W + SAMPLE_W;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN    = -ACC_W'(1 << (SAMPLE_W - 1));

    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_xh [ORDER];
    logic signed [PROD_W-1:0] prod_yh [ORDER];
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [ACC_W-1:0]  scaled;

    always_comb
    begin
        prod_x = $signed(coefs[0]) * x;
        acc    = ACC_W'(prod_x);
        for (int k = 0; k < ORDER; k++)
        begin
            prod_xh[k] = $signed(coefs[1 + k]) * $signed(xh[k]);
            prod_yh[k] = $signed(coefs[ORDER + 1 + k]) * $signed(yh[k]);
            acc = acc + ACC_W'(prod_xh[k]) - ACC_W'(prod_yh[k]);
        end
        rounded = acc + ROUND_HALF;
        scaled  = rounded >>> FRAC_BITS;

        if (scaled > SAT_MAX)
        begin
            result.filtered = SAT_MAX[SAMPLE_W-1:0];
            result.clipped  = 1'b1;
        end
        else if (scaled < SAT_MIN)
        begin
            result.filtered = SAT_MIN[SAMPLE_W-1:0];
            result.clipped  = 1'b1;
        end
        else
        begin
            result.filtered = scaled[SAMPLE_W-1:0];
            result.clipped  = 1'b0;
        end
    end

endmodule : mcbq_mac
`default_nettype wire
